// ----- hdl/grid_mine_neighbor_count_defines.svh -----
// ---------------------------------------------------------------------------
// grid_mine_neighbor_count assertion macros
// Shared concurrent assertion forms. They sample on i_clk and are disabled
// while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef GRID_MINE_NEIGHBOR_COUNT_DEFINES_SVH
`define GRID_MINE_NEIGHBOR_COUNT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GMNC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GMNC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/gmnc_pkg.sv -----
// ---------------------------------------------------------------------------
// gmnc_pkg
// Types and fixed constants shared by the mine neighbour counter modules.
// ---------------------------------------------------------------------------
package gmnc_pkg;

    // Configuration register widths, indexes and reset values.
    localparam int CFG_ROWS_W = 11;
    localparam int CFG_COLS_W = 6;
    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 2'd1;
    localparam logic [CFG_ROWS_W-1:0] ROWS_RESET = 11'd1024;
    localparam logic [CFG_COLS_W-1:0] COLS_RESET = 6'd32;

    // Result field widths.
    localparam int OUT_ROW_W   = 10;
    localparam int OUT_COL_W   = 5;
    localparam int OUT_COUNT_W = 4;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 24;

    // Row slot of the three-row rotating store (row index modulo three).
    typedef logic [1:0] t_slot;
    localparam t_slot SLOT_LAST = 2'd2;

    // One column of the store: one bit per row slot.
    typedef logic [2:0] t_cells;

    typedef struct packed {
        logic  en;
        t_slot slot;
        logic  bit_val;
    } t_store_wr;

    function automatic t_slot slot_next(input t_slot s);
        return (s == SLOT_LAST) ? t_slot'(0) : s + t_slot'(1);
    endfunction

    function automatic t_slot slot_prev(input t_slot s);
        return (s == t_slot'(0)) ? SLOT_LAST : s - t_slot'(1);
    endfunction

endpackage

// ----- hdl/gmnc_line_store.sv -----
// ---------------------------------------------------------------------------
// gmnc_line_store
// Column-organised line store: one entry per grid column, each entry holding
// the cell of that column for the three resident rows. Single write port
// with a per-slot bit enable, two read ports with registered data.
// ---------------------------------------------------------------------------
module gmnc_line_store
    import gmnc_pkg::*;
#(
    parameter int MAX_COLS = 32
) (
    input  logic                                           i_clk,
    input  t_store_wr                                      i_wr,
    input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] i_wr_addr,
    input  logic                                           i_rd_en,
    input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] i_rd_addr_a,
    input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] i_rd_addr_b,
    output t_cells                                         o_rd_data_a,
    output t_cells                                         o_rd_data_b
);

    t_cells r_mem [MAX_COLS];
    t_cells r_rd_a;
    t_cells r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr_addr][i_wr.slot] <= i_wr.bit_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ----- hdl/grid_mine_neighbor_count.sv -----
// ---------------------------------------------------------------------------
// grid_mine_neighbor_count
// Streaming minesweeper neighbour counter. Cells arrive in raster order and
// each cell is reported once its lower-right neighbour has arrived, with the
// mine flag and, for an empty cell, the number of neighbouring mines.
// ---------------------------------------------------------------------------
// Channel  Dir  Handshake                  Payload
// s        in   i_s_tvalid / o_s_tready     i_s_tdata: cell_is_mine
// m        out  o_m_tvalid / i_m_tready     o_m_tdata, o_m_tuser, o_m_tlast
// cfg      in   i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// An input transaction is taken in the idle state; every result it releases
// then passes two line store read states (left and centre columns, then the
// right column) and one state to count and load the output register. A
// typical cell gives one result, a row end two and the last cell of a frame
// up to four; a cell that releases nothing leaves the block idle. A full
// output register stalls the count state. The line store needs no clearing
// pass after reset: a cell is only read after it was written in the current
// frame. A write to the row or column count register restarts the frame.
// ---------------------------------------------------------------------------
`include "grid_mine_neighbor_count_defines.svh"

module grid_mine_neighbor_count
    import gmnc_pkg::*;
#(
    parameter int MAX_COLS = 32,
    parameter int MAX_ROWS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input cells
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,    // [0] cell_is_mine, [7:1] zero
    // Results
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,    // [9:0] out_row, [14:10] out_col,
                                                // [18:15] mine_count, [23:19] zero
    output logic                  o_m_tuser,    // [0] out_is_mine
    output logic                  o_m_tlast,    // run_last
    // Configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_ROWS_W-1:0] i_cfg_data
);

    localparam int ROW_W   = CFG_ROWS_W;
    localparam int COL_W   = CFG_COLS_W;
    localparam int AW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int MAX_RES = MAX_COLS + 1;
    localparam int K_W     = $clog2(MAX_COLS + 2);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RD0  = 4'b0010,
        ST_RD1  = 4'b0100,
        ST_CALC = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [ROW_W-1:0]   r_rows_cfg, n_rows_cfg;
    logic [COL_W-1:0]   r_cols_cfg, n_cols_cfg;
    logic [ROW_W-1:0]   r_in_row, n_in_row;
    logic [COL_W-1:0]   r_in_col, n_in_col;
    t_slot              r_in_slot, n_in_slot;
    logic [ROW_W-1:0]   r_em_row, n_em_row;
    logic [COL_W-1:0]   r_em_col, n_em_col;
    t_slot              r_em_slot, n_em_slot;
    logic               r_final, n_final;
    logic [K_W-1:0]     r_k, n_k;
    logic               r_out_valid, n_out_valid;

    // Payload registers
    logic [ROW_W-1:0]   r_arr_row;
    logic [COL_W-1:0]   r_arr_col;
    t_cells             r_win_l;
    t_cells             r_win_c;
    logic [OUT_ROW_W-1:0]   r_out_row;
    logic [OUT_COL_W-1:0]   r_out_col;
    logic                   r_out_mine;
    logic [OUT_COUNT_W-1:0] r_out_count;
    logic                   r_out_last;

    logic               in_acc;
    logic               cfg_acc;
    logic [ROW_W-1:0]   nr;
    logic [COL_W-1:0]   nc;
    logic               in_final;
    logic               start_ok;
    logic               emit_now;
    logic               next_ok;
    logic [ROW_W-1:0]   step_row;
    logic [COL_W-1:0]   step_col;
    t_slot              step_slot;
    logic [COL_W:0]     ec_ext;
    logic [COL_W:0]     left_col;
    logic [COL_W:0]     right_col;
    t_slot              s_up;
    t_slot              s_dn;
    logic               up_ok, dn_ok, lf_ok, rt_ok;
    logic [7:0]         nb;
    logic [OUT_COUNT_W-1:0] nb_sum;
    logic               cell_mine;

    t_store_wr          wr;
    logic [AW-1:0]      wr_addr;
    logic               rd_en;
    logic [AW-1:0]      rd_addr_a;
    logic [AW-1:0]      rd_addr_b;
    t_cells             rd_data_a;
    t_cells             rd_data_b;

    // Column to store address; columns beyond the store only feed masked taps.
    function automatic logic [AW-1:0] col_addr(input logic [COL_W:0] c);
        return (c < (COL_W+1)'(MAX_COLS)) ? c[AW-1:0] : '0;
    endfunction

    // True when cell (er, ec) may be reported given the last arrived cell.
    function automatic logic emit_ok(
        input logic [ROW_W-1:0] er,
        input logic [COL_W-1:0] ec,
        input logic [K_W-1:0]   k,
        input logic [ROW_W-1:0] ar,
        input logic [COL_W-1:0] ac,
        input logic [ROW_W-1:0] rows,
        input logic [COL_W-1:0] cols
    );
        logic [ROW_W:0] lr;
        logic [COL_W:0] lc;
        lr = (({1'b0, er} + (ROW_W+1)'(1)) < {1'b0, rows}) ?
             ({1'b0, er} + (ROW_W+1)'(1)) : ({1'b0, rows} - (ROW_W+1)'(1));
        lc = (({1'b0, ec} + (COL_W+1)'(1)) < {1'b0, cols}) ?
             ({1'b0, ec} + (COL_W+1)'(1)) : ({1'b0, cols} - (COL_W+1)'(1));
        return (er < rows) && (k < K_W'(MAX_RES)) &&
               ((lr < {1'b0, ar}) || ((lr == {1'b0, ar}) && (lc <= {1'b0, ac})));
    endfunction

    // Effective frame size: zero acts as one, oversize saturates.
    always_comb begin
        if (r_rows_cfg == '0) begin
            nr = ROW_W'(1);
        end else if (32'(r_rows_cfg) > MAX_ROWS) begin
            nr = ROW_W'(MAX_ROWS);
        end else begin
            nr = r_rows_cfg;
        end
        if (r_cols_cfg == '0) begin
            nc = COL_W'(1);
        end else if (32'(r_cols_cfg) > MAX_COLS) begin
            nc = COL_W'(MAX_COLS);
        end else begin
            nc = r_cols_cfg;
        end
    end

    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_s_tready  = (r_state == ST_IDLE) && !i_cfg_valid;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign in_acc      = i_s_tvalid && o_s_tready;

    assign in_final = (r_in_row == nr - ROW_W'(1)) && (r_in_col == nc - COL_W'(1));
    assign start_ok = emit_ok(r_em_row, r_em_col, '0, r_in_row, r_in_col, nr, nc);

    // Neighbourhood of the cell being reported.
    assign ec_ext    = {1'b0, r_em_col};
    assign left_col  = (r_em_col == '0) ? '0 : ec_ext - (COL_W+1)'(1);
    assign right_col = ec_ext + (COL_W+1)'(1);
    assign s_up      = slot_prev(r_em_slot);
    assign s_dn      = slot_next(r_em_slot);
    assign up_ok     = (r_em_row != '0);
    assign dn_ok     = (({1'b0, r_em_row} + (ROW_W+1)'(1)) < {1'b0, nr});
    assign lf_ok     = (r_em_col != '0);
    assign rt_ok     = (right_col < {1'b0, nc});

    always_comb begin
        nb[0] = r_win_l[s_up] & up_ok & lf_ok;
        nb[1] = r_win_c[s_up] & up_ok;
        nb[2] = rd_data_a[s_up] & up_ok & rt_ok;
        nb[3] = r_win_l[r_em_slot] & lf_ok;
        nb[4] = rd_data_a[r_em_slot] & rt_ok;
        nb[5] = r_win_l[s_dn] & dn_ok & lf_ok;
        nb[6] = r_win_c[s_dn] & dn_ok;
        nb[7] = rd_data_a[s_dn] & dn_ok & rt_ok;
        nb_sum = '0;
        for (int i = 0; i < 8; i++) begin
            nb_sum = nb_sum + OUT_COUNT_W'(nb[i]);
        end
    end

    assign cell_mine = r_win_c[r_em_slot];

    // Raster step of the report position after this cell.
    always_comb begin
        if (!rt_ok) begin
            step_col  = '0;
            step_row  = r_em_row + ROW_W'(1);
            step_slot = s_dn;
        end else begin
            step_col  = r_em_col + COL_W'(1);
            step_row  = r_em_row;
            step_slot = r_em_slot;
        end
    end

    assign emit_now = (r_state == ST_CALC) && (!r_out_valid || i_m_tready);
    assign next_ok  = emit_ok(step_row, step_col, r_k + K_W'(1), r_arr_row, r_arr_col,
                              nr, nc);

    // Line store access. Reads only run in the read states, after the write
    // of the arrived cell has landed, so no forwarding path is needed.
    always_comb begin
        wr.en      = in_acc;
        wr.slot    = r_in_slot;
        wr.bit_val = i_s_tdata[0];
        wr_addr    = col_addr({1'b0, r_in_col});
        rd_en      = (r_state == ST_RD0) || (r_state == ST_RD1);
        rd_addr_a  = (r_state == ST_RD0) ? col_addr(left_col) : col_addr(right_col);
        rd_addr_b  = col_addr(ec_ext);
    end

    gmnc_line_store #(
        .MAX_COLS (MAX_COLS)
    ) u_line_store (
        .i_clk       (i_clk),
        .i_wr        (wr),
        .i_wr_addr   (wr_addr),
        .i_rd_en     (rd_en),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

    always_comb begin
        n_state     = r_state;
        n_rows_cfg  = r_rows_cfg;
        n_cols_cfg  = r_cols_cfg;
        n_in_row    = r_in_row;
        n_in_col    = r_in_col;
        n_in_slot   = r_in_slot;
        n_em_row    = r_em_row;
        n_em_col    = r_em_col;
        n_em_slot   = r_em_slot;
        n_final     = r_final;
        n_k         = r_k;
        n_out_valid = r_out_valid;

        if (i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (cfg_acc) begin
                    if (i_cfg_index == REG_ROWS_IN_USE) begin
                        n_rows_cfg = i_cfg_data;
                    end
                    if (i_cfg_index == REG_COLS_IN_USE) begin
                        n_cols_cfg = i_cfg_data[COL_W-1:0];
                    end
                    if (i_cfg_index inside {REG_ROWS_IN_USE, REG_COLS_IN_USE}) begin
                        n_in_row  = '0;
                        n_in_col  = '0;
                        n_in_slot = '0;
                        n_em_row  = '0;
                        n_em_col  = '0;
                        n_em_slot = '0;
                        n_final   = 1'b0;
                    end
                end else if (in_acc) begin
                    n_final = in_final;
                    n_k     = '0;
                    if (in_final) begin
                        n_in_row  = '0;
                        n_in_col  = '0;
                        n_in_slot = '0;
                    end else if (({1'b0, r_in_col} + (COL_W+1)'(1)) >= {1'b0, nc}) begin
                        n_in_col  = '0;
                        n_in_row  = r_in_row + ROW_W'(1);
                        n_in_slot = slot_next(r_in_slot);
                    end else begin
                        n_in_col = r_in_col + COL_W'(1);
                    end
                    if (start_ok) begin
                        n_state = ST_RD0;
                    end else if (in_final) begin
                        n_em_row  = '0;
                        n_em_col  = '0;
                        n_em_slot = '0;
                    end
                end
            end
            ST_RD0: begin
                n_state = ST_RD1;
            end
            ST_RD1: begin
                n_state = ST_CALC;
            end
            ST_CALC: begin
                if (emit_now) begin
                    n_out_valid = 1'b1;
                    n_k         = r_k + K_W'(1);
                    n_em_row    = step_row;
                    n_em_col    = step_col;
                    n_em_slot   = step_slot;
                    if (next_ok) begin
                        n_state = ST_RD0;
                    end else begin
                        n_state = ST_IDLE;
                        // The last cell of a frame has flushed all it may.
                        if (r_final) begin
                            n_em_row  = '0;
                            n_em_col  = '0;
                            n_em_slot = '0;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rows_cfg  <= ROWS_RESET;
            r_cols_cfg  <= COLS_RESET;
            r_in_row    <= '0;
            r_in_col    <= '0;
            r_in_slot   <= '0;
            r_em_row    <= '0;
            r_em_col    <= '0;
            r_em_slot   <= '0;
            r_final     <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rows_cfg  <= n_rows_cfg;
            r_cols_cfg  <= n_cols_cfg;
            r_in_row    <= n_in_row;
            r_in_col    <= n_in_col;
            r_in_slot   <= n_in_slot;
            r_em_row    <= n_em_row;
            r_em_col    <= n_em_col;
            r_em_slot   <= n_em_slot;
            r_final     <= n_final;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_arr_row <= r_in_row;
            r_arr_col <= r_in_col;
        end
        if (r_state == ST_RD1) begin
            r_win_l <= (r_em_col == '0) ? t_cells'(0) : rd_data_a;
            r_win_c <= rd_data_b;
        end
        if (emit_now) begin
            r_out_row   <= r_em_row[OUT_ROW_W-1:0];
            r_out_col   <= r_em_col[OUT_COL_W-1:0];
            r_out_mine  <= cell_mine;
            r_out_count <= cell_mine ? '0 : nb_sum;
            r_out_last  <= !next_ok;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_out_count, r_out_col, r_out_row};
    assign o_m_tuser  = r_out_mine;
    assign o_m_tlast  = r_out_last;

    `GMNC_ASSERT_NOW(a_no_rd_on_wr, wr.en, !rd_en, "line store read collides with write")
    `GMNC_ASSERT_NEXT(a_acc_to_rd, in_acc, (r_state == ST_IDLE || r_state == ST_RD0),
        "accepted cell did not start reporting or return to idle")
    `GMNC_ASSERT_NOW(a_em_in_frame, (r_state != ST_IDLE),
        (r_em_row < nr && r_em_col < nc), "report position outside the frame")
    `GMNC_ASSERT_NOW(a_k_cap, 1'b1, (r_k <= K_W'(MAX_RES)), "results per cell above cap")

endmodule
